[design/kcalc_pkg.sv]
package kcalc_pkg;

  // Sequencer phase: which part of the expression the next key fills
  typedef enum logic [2:0] {
    PH_X_TENS,
    PH_X_ONES,
    PH_OPER,
    PH_Y_TENS,
    PH_Y_ONES
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CALC,
    S_DIV,
    S_OUT
  } ctrl_state_t;

  typedef logic [3:0] key_code_t;

  // Operator keys and digit limit
  localparam key_code_t KEY_ADD     = 4'hA;
  localparam key_code_t KEY_SUB     = 4'hB;
  localparam key_code_t KEY_MUL     = 4'hC;
  localparam key_code_t KEY_DIV     = 4'hD;
  localparam key_code_t DIGIT_LIMIT = 4'd10;

  // LED progress marks
  localparam logic [7:0] LED_X_DONE  = 8'h01;
  localparam logic [7:0] LED_OP_DONE = 8'h03;

  // Restoring divider: one quotient bit per cycle over an 8-bit dividend
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Key map by column, then row 0..3
  localparam key_code_t KEY_MAP [4][4] = '{
    '{4'hD, 4'hC, 4'hB, 4'hA},
    '{4'hF, 4'h9, 4'h6, 4'h3},
    '{4'h0, 4'h8, 4'h5, 4'h2},
    '{4'hE, 4'h7, 4'h4, 4'h1}
  };

  typedef struct packed {
    logic      valid;
    key_code_t code;
  } key_dec_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic step;
    logic calc;
    logic div_step;
    logic load_out;
  } kcalc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic finish;
    logic div_start;
    logic div_last;
  } kcalc_status_t;

  // Decode one scan snapshot; the lowest matching column wins
  function automatic key_dec_t decode_key(input logic [15:0] m);
    key_dec_t   d;
    logic [3:0] nib;
    logic [1:0] row;
    logic       hit;
    d = '0;
    for (int col = 3; col >= 0; col--) begin
      nib = m[col*4 +: 4];
      hit = 1'b1;
      unique case (nib)
        4'b0001: row = 2'd0;
        4'b0010: row = 2'd1;
        4'b0100: row = 2'd2;
        4'b1000: row = 2'd3;
        default: begin
          row = 2'd0;
          hit = 1'b0;
        end
      endcase
      if (hit) begin
        d.valid = 1'b1;
        d.code  = KEY_MAP[col][row];
      end
    end
    return d;
  endfunction

endpackage

[design/kcalc_if.sv]
// Keypad snapshot channel
interface kcalc_key_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_matrix;

  modport source (output valid, output key_matrix, input ready);
  modport sink   (input valid, input key_matrix, output ready);
endinterface

// Result channel
interface kcalc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_pattern;
  logic       key_valid;
  logic [3:0] key_code;
  logic       result_ready;

  modport source (output valid, output led_pattern, output key_valid, output key_code,
                  output result_ready, input ready);
  modport sink   (input valid, input led_pattern, input key_valid, input key_code,
                  input result_ready, output ready);
endinterface

[design/kcalc_ctrl.sv]
module kcalc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  kcalc_pkg::kcalc_status_t st,
  output kcalc_pkg::kcalc_cmd_t    cmd
);

  kcalc_pkg::ctrl_state_t state;
  kcalc_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcalc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      kcalc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = kcalc_pkg::S_DECODE;
        end
      end
      kcalc_pkg::S_DECODE: begin
        cmd.step   = 1'b1;
        state_next = st.finish ? kcalc_pkg::S_CALC : kcalc_pkg::S_OUT;
      end
      kcalc_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = st.div_start ? kcalc_pkg::S_DIV : kcalc_pkg::S_OUT;
      end
      kcalc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = kcalc_pkg::S_OUT;
        end
      end
      kcalc_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = kcalc_pkg::S_IDLE;
        end
      end
      default: state_next = kcalc_pkg::S_IDLE;
    endcase
  end

  // Output register occupancy: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while holding a result");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == kcalc_pkg::S_DECODE))
    else $error("accepted snapshot not decoded next cycle");

endmodule

[design/kcalc_dp.sv]
module kcalc_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  kcalc_pkg::kcalc_cmd_t    cmd,
  output kcalc_pkg::kcalc_status_t st,
  input  logic [15:0]              key_matrix,
  output logic [7:0]               led_pattern,
  output logic                     key_valid,
  output logic [3:0]               key_code,
  output logic                     result_ready
);

  logic [15:0]                     matrix_q;
  kcalc_pkg::phase_t               phase;
  logic [6:0]                      operand_x;
  kcalc_pkg::key_code_t            operator_key;
  kcalc_pkg::key_code_t            operand_y_tens;
  logic [6:0]                      operand_y;
  logic [7:0]                      led_hold;
  logic                            kv;
  kcalc_pkg::key_code_t            kc;
  logic                            rdy;
  logic [7:0]                      div_rem;
  logic [7:0]                      div_quo;
  logic [kcalc_pkg::DIV_CNT_W-1:0] div_cnt;

  kcalc_pkg::key_dec_t dec;
  logic                digit;
  logic [6:0]          code_times_ten;
  logic [6:0]          ytens_times_ten;
  logic [6:0]          y_full;
  logic [13:0]         product;
  logic [7:0]          arith_result;
  logic [7:0]          div_shift;
  logic                div_ge;
  logic [7:0]          div_rem_next;
  logic [7:0]          div_quo_next;

  // Decode the held snapshot and form the operand arithmetic
  always_comb begin
    dec             = kcalc_pkg::decode_key(matrix_q);
    digit           = dec.valid && (dec.code < kcalc_pkg::DIGIT_LIMIT);
    code_times_ten  = ({3'b0, dec.code} << 3) + ({3'b0, dec.code} << 1);
    ytens_times_ten = ({3'b0, operand_y_tens} << 3) + ({3'b0, operand_y_tens} << 1);
    y_full          = ytens_times_ten + {3'b0, dec.code};
    product         = operand_x * operand_y;
    unique case (operator_key)
      kcalc_pkg::KEY_ADD: arith_result = {1'b0, operand_x} + {1'b0, operand_y};
      kcalc_pkg::KEY_SUB: arith_result = {1'b0, operand_x} - {1'b0, operand_y};
      kcalc_pkg::KEY_MUL: arith_result = product[7:0];
      default:            arith_result = 8'h00;
    endcase
  end

  // One restoring divide step
  always_comb begin
    div_shift    = {div_rem[6:0], div_quo[7]};
    div_ge       = div_shift >= {1'b0, operand_y};
    div_rem_next = div_ge ? (div_shift - {1'b0, operand_y}) : div_shift;
    div_quo_next = {div_quo[6:0], div_ge};
  end

  // Status to the controller
  always_comb begin
    st.finish    = (phase == kcalc_pkg::PH_Y_ONES) && digit;
    st.div_start = (operator_key == kcalc_pkg::KEY_DIV) && (operand_y != 7'd0);
    st.div_last  = (div_cnt == '0);
  end

  // Capture the snapshot on transfer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      matrix_q <= key_matrix;
    end
  end

  // Sequencer state and LED value
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kcalc_pkg::PH_X_TENS;
      operand_x      <= '0;
      operator_key   <= '0;
      operand_y_tens <= '0;
      led_hold       <= '0;
    end else if (cmd.step) begin
      if (dec.valid) begin
        unique case (phase)
          kcalc_pkg::PH_X_ONES: begin
            if (digit) begin
              operand_x <= operand_x + {3'b0, dec.code};
              led_hold  <= kcalc_pkg::LED_X_DONE;
              phase     <= kcalc_pkg::PH_OPER;
            end
          end
          kcalc_pkg::PH_OPER: begin
            if (!digit) begin
              operator_key <= dec.code;
              led_hold     <= kcalc_pkg::LED_OP_DONE;
              phase        <= kcalc_pkg::PH_Y_TENS;
            end
          end
          kcalc_pkg::PH_Y_TENS: begin
            if (digit) begin
              operand_y_tens <= dec.code;
              phase          <= kcalc_pkg::PH_Y_ONES;
            end
          end
          kcalc_pkg::PH_Y_ONES: begin
            if (digit) begin
              phase <= kcalc_pkg::PH_X_TENS;
            end
          end
          default: begin
            if (digit) begin
              operand_x <= code_times_ten;
              phase     <= kcalc_pkg::PH_X_ONES;
            end
          end
        endcase
      end
    end else if (cmd.calc) begin
      if (!st.div_start) begin
        led_hold <= arith_result;
      end
    end else if (cmd.div_step && st.div_last) begin
      led_hold <= div_quo_next;
    end
  end

  // Per-item flags and the Y operand
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kv        <= dec.valid;
      kc        <= dec.code;
      rdy       <= st.finish;
      operand_y <= y_full;
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      div_rem <= '0;
      div_quo <= {1'b0, operand_x};
      div_cnt <= kcalc_pkg::DIV_CNT_W'(kcalc_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      led_pattern  <= led_hold;
      key_valid    <= kv;
      key_code     <= kc;
      result_ready <= rdy;
    end
  end

  a_finish_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && st.finish) |=> (phase == kcalc_pkg::PH_X_TENS && rdy))
    else $error("completed Y did not restart the sequencer");

  a_no_key_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !dec.valid) |=> ($stable(phase) && !kv && kc == '0))
    else $error("empty snapshot changed the sequencer");

endmodule

[design/keypad_two_digit_calculator.sv]
// Two-digit keypad calculator.
// key_in carries one 4x4 keypad scan snapshot per transfer (nibble i = rows read
// with column i driven). Each snapshot gives exactly one item on result_out:
// the LED value after that key, whether a key was decoded, its code, and a
// flag on the key that completed Y and produced a result.
// Each item goes from the input transfer through S_DECODE to S_OUT, which loads
// the result into the output register; when Y completes it also passes S_CALC,
// and a divide by a nonzero Y then runs the 8-step restoring divider in S_DIV.
// The next snapshot can be taken in the cycle after the result is loaded, and
// none is accepted while the previous one is still being worked on.
// The output register frees the input side: a new snapshot is accepted while
// the previous result waits. If the receiver stalls, the finished item holds
// in the controller until the output register drains.
// Synchronous reset clears the sequencer to await the X tens digit, clears X, the
// operator, the Y tens digit and the LED value, and empties the output register.
module keypad_two_digit_calculator (
  input  logic        clk,
  input  logic        rst,
  kcalc_key_if.sink   key_in,
  kcalc_res_if.source result_out
);

  kcalc_pkg::kcalc_cmd_t    cmd;
  kcalc_pkg::kcalc_status_t st;

  kcalc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  kcalc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .key_matrix   (key_in.key_matrix),
    .led_pattern  (result_out.led_pattern),
    .key_valid    (result_out.key_valid),
    .key_code     (result_out.key_code),
    .result_ready (result_out.result_ready)
  );

endmodule

[sim/keypad_two_digit_calculator_tb.sv]
module keypad_two_digit_calculator_tb;

  // Keys outside the arithmetic set
  localparam kcalc_pkg::key_code_t KEY_STAR  = 4'hE;
  localparam kcalc_pkg::key_code_t KEY_POUND = 4'hF;

  localparam int RANDOM_KEYS   = 525;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 80;
  localparam int DRAIN_CYCLES  = 30;
  localparam int LOG_LIMIT     = 100;

  // Pad layout by column, then row 0..3
  localparam kcalc_pkg::key_code_t PAD_LAYOUT [4][4] = '{
    '{kcalc_pkg::KEY_DIV, kcalc_pkg::KEY_MUL, kcalc_pkg::KEY_SUB, kcalc_pkg::KEY_ADD},
    '{KEY_POUND,          4'd9,               4'd6,               4'd3},
    '{4'd0,               4'd8,               4'd5,               4'd2},
    '{KEY_STAR,           4'd7,               4'd4,               4'd1}
  };

  typedef struct packed {
    logic [7:0]           led;
    logic                 kv;
    kcalc_pkg::key_code_t kc;
    logic                 rr;
  } display_t;

  typedef struct packed {
    logic [15:0] m;
    logic        typed;
    display_t    want;
  } plan_row_t;

  logic clk;
  logic rst;

  kcalc_key_if key_ch ();
  kcalc_res_if res_ch ();

  keypad_two_digit_calculator dut (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_ch),
    .result_out (res_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Calculator shadow state
  kcalc_pkg::phase_t    ph_q  = kcalc_pkg::PH_X_TENS;
  logic [6:0]           x_q   = '0;
  kcalc_pkg::key_code_t op_q  = '0;
  logic [3:0]           yt_q  = '0;
  logic [7:0]           led_q = '0;

  display_t due_displays [$];
  int       errors       = 0;
  int       results_seen = 0;
  logic     cur_typed;
  display_t cur_want;

  // Directed snapshots; typed rows carry their display, the rest use the predictor
  plan_row_t plan [0:24] = '{
    '{16'h0000, 1'b1, '{8'h00, 1'b0, 4'h0, 1'b0}},  // no key
    '{16'hFFFF, 1'b1, '{8'h00, 1'b0, 4'h0, 1'b0}},  // every line high
    '{16'h0013, 1'b1, '{8'h00, 1'b1, 4'hF, 1'b0}},  // two rows in col 0, pound ignored
    '{16'h0020, 1'b0, '0},                          // 9
    '{16'h0008, 1'b0, '0},                          // add in digit phase
    '{16'h0020, 1'b1, '{8'h01, 1'b1, 4'h9, 1'b0}},  // X = 99
    '{16'h0100, 1'b0, '0},                          // digit in operator phase
    '{16'h0001, 1'b1, '{8'h03, 1'b1, 4'hD, 1'b0}},  // divide
    '{16'h0100, 1'b0, '0},
    '{16'h0100, 1'b1, '{8'h00, 1'b1, 4'h0, 1'b1}},  // divide by zero
    '{16'h0020, 1'b0, '0},
    '{16'h0020, 1'b0, '0},
    '{16'h0008, 1'b0, '0},
    '{16'h0020, 1'b0, '0},
    '{16'h0020, 1'b1, '{8'hC6, 1'b1, 4'h9, 1'b1}},  // 99 + 99
    '{16'h0100, 1'b0, '0},
    '{16'h0100, 1'b0, '0},
    '{16'h0004, 1'b0, '0},
    '{16'h0020, 1'b0, '0},
    '{16'h0020, 1'b1, '{8'h9D, 1'b1, 4'h9, 1'b1}},  // 0 - 99 wraps
    '{16'h0020, 1'b0, '0},
    '{16'h0020, 1'b0, '0},
    '{16'h0002, 1'b0, '0},
    '{16'h0020, 1'b0, '0},
    '{16'h0020, 1'b1, '{8'h49, 1'b1, 4'h9, 1'b1}}   // 99 * 99 wraps
  };

  // Advance the shadow calculator by one snapshot and return the display
  function automatic display_t step_calculator(input logic [15:0] m);
    display_t             o;
    logic [3:0]           nib;
    logic [7:0]           x8;
    logic [7:0]           y;
    logic                 hit;
    kcalc_pkg::key_code_t code;
    hit  = 1'b0;
    code = '0;
    o    = '0;
    for (int c = 0; c < 4; c++) begin
      nib = m[c*4 +: 4];
      if (!hit && $countones(nib) == 1) begin
        hit  = 1'b1;
        code = PAD_LAYOUT[c][$clog2(nib)];
      end
    end
    if (ph_q > kcalc_pkg::PH_Y_ONES) ph_q = kcalc_pkg::PH_X_TENS;
    if (hit) begin
      case (ph_q)
        kcalc_pkg::PH_X_TENS: begin
          if (code < kcalc_pkg::DIGIT_LIMIT) begin
            x_q  = code * 7'd10;
            ph_q = kcalc_pkg::PH_X_ONES;
          end
        end
        kcalc_pkg::PH_X_ONES: begin
          if (code < kcalc_pkg::DIGIT_LIMIT) begin
            x_q   = x_q + code;
            led_q = kcalc_pkg::LED_X_DONE;
            ph_q  = kcalc_pkg::PH_OPER;
          end
        end
        kcalc_pkg::PH_OPER: begin
          if (code >= kcalc_pkg::KEY_ADD) begin
            op_q  = code;
            led_q = kcalc_pkg::LED_OP_DONE;
            ph_q  = kcalc_pkg::PH_Y_TENS;
          end
        end
        kcalc_pkg::PH_Y_TENS: begin
          if (code < kcalc_pkg::DIGIT_LIMIT) begin
            yt_q = code;
            ph_q = kcalc_pkg::PH_Y_ONES;
          end
        end
        default: begin
          if (code < kcalc_pkg::DIGIT_LIMIT) begin
            x8 = {1'b0, x_q};
            y  = yt_q * 8'd10 + code;
            case (op_q)
              kcalc_pkg::KEY_ADD: led_q = x8 + y;
              kcalc_pkg::KEY_SUB: led_q = x8 - y;
              kcalc_pkg::KEY_MUL: led_q = x8 * y;
              kcalc_pkg::KEY_DIV: led_q = (y != 8'd0) ? x8 / y : 8'h00;
              default:            led_q = 8'h00;
            endcase
            o.rr = 1'b1;
            ph_q = kcalc_pkg::PH_X_TENS;
          end
        end
      endcase
    end
    o.led = led_q;
    o.kv  = hit;
    o.kc  = code;
    return o;
  endfunction

  // Any nibble that is not one-hot, so the column never matches
  function automatic logic [3:0] bad_nibble();
    logic [3:0] n;
    do n = 4'($urandom_range(0, 15)); while ($countones(n) == 1);
    return n;
  endfunction

  // Build a snapshot for one key: dead columns below it, random lines above it
  function automatic logic [15:0] matrix_for_key(input kcalc_pkg::key_code_t code);
    logic [15:0] m;
    int          col;
    int          row;
    col = 0;
    row = 0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (PAD_LAYOUT[c][r] == code) begin
          col = c;
          row = r;
        end
    for (int c = 0; c < 4; c++) begin
      if (c < col) m[c*4 +: 4] = bad_nibble();
      else if (c == col) m[c*4 +: 4] = 4'b0001 << row;
      else m[c*4 +: 4] = 4'($urandom_range(0, 15));
    end
    return m;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic kcalc_pkg::key_code_t pick_digit();
    if ($urandom_range(0, 3) == 0) return 4'd0;
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic kcalc_pkg::key_code_t pick_operator();
    if ($urandom_range(0, 99) < 85) return kcalc_pkg::KEY_ADD + 4'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? KEY_STAR : KEY_POUND;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    // keep the log short when everything goes wrong
    if (errors < LOG_LIMIT)
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offer one snapshot after a random gap and hold it until the transfer
  task automatic send_key(input logic [15:0] m, input logic typed, input display_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.key_matrix <= m;
    cur_typed         <= typed;
    cur_want          <= want;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
  endtask

  // Send the first keys of a random expression: X tens, X ones, operator, Y tens, Y ones
  task automatic send_expression(input int keys);
    kcalc_pkg::key_code_t seq [5];
    seq[0] = pick_digit();
    seq[1] = pick_digit();
    seq[2] = pick_operator();
    seq[3] = pick_digit();
    seq[4] = pick_digit();
    for (int k = 0; k < keys; k++) send_key(matrix_for_key(seq[k]), 1'b0, '0);
  endtask

  // Predict on every input transfer, compare on every output transfer
  always @(posedge clk) begin : scoreboard
    display_t want;
    display_t got;
    if (!rst) begin
      if (key_ch.valid && key_ch.ready) begin
        want = step_calculator(key_ch.key_matrix);
        if (cur_typed) want = cur_want;
        due_displays.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        got = '{res_ch.led_pattern, res_ch.key_valid, res_ch.key_code, res_ch.result_ready};
        if (due_displays.size() == 0) begin
          report_mismatch("unexpected result", got, 0);
        end else begin
          want = due_displays.pop_front();
          check_field("led_pattern", got.led, want.led);
          check_field("key_valid", got.kv, want.kv);
          check_field("key_code", got.kc, want.kc);
          check_field("result_ready", got.rr, want.rr);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  initial begin : receiver
    bit held;
    int run;
    int gap;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      res_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int keys_sent;
    rst               = 1'b1;
    key_ch.valid      = 1'b0;
    key_ch.key_matrix = '0;
    cur_typed         = 1'b0;
    cur_want          = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (plan[i]) send_key(plan[i].m, plan[i].typed, plan[i].want);

    // Random: mostly whole expressions, the rest broken ones and noise
    keys_sent = 0;
    while (keys_sent < RANDOM_KEYS) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_expression(5);
        keys_sent += 5;
      end else if (r < 80) begin
        n = $urandom_range(1, 4);
        send_expression(n);
        keys_sent += n;
      end else if (r < 88) begin
        send_key(16'($urandom_range(0, 65535)), 1'b0, '0);
        keys_sent += 1;
      end else if (r < 94) begin
        send_key(matrix_for_key(4'($urandom_range(0, 15))), 1'b0, '0);
        keys_sent += 1;
      end else begin
        send_key({bad_nibble(), bad_nibble(), bad_nibble(), bad_nibble()}, 1'b0, '0);
        keys_sent += 1;
      end
    end
    key_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (due_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
